// ===== src/wtosc_pkg.sv =====
// Shared constants, codes and controller/datapath types for the wavetable oscillator.
package wtosc_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int SAMPLE_W        = 16;
   localparam int FRAC_W          = 16;
   localparam int INC_W           = 26;
   localparam int GAIN_W          = 16;
   localparam int GAIN_FRAC       = 15;
   localparam int LEN_W           = 11;
   localparam int ADDR_W          = 11;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 26;
   localparam int MIN_LEN         = 2;
   localparam int RESET_GAIN      = 32768;
   localparam int RESET_LEN       = 1024;

   // phase keeps one spare integer bit so any clamped length fits
   localparam int PH_W   = LEN_W + FRAC_W;
   // integer part of phase plus increment
   localparam int NUM_W  = LEN_W + 1;
   localparam int MUL_W  = SAMPLE_W + FRAC_W + 2;
   localparam int GMUL_W = SAMPLE_W + GAIN_W + 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PHASE_INC = 2'd0,
      CSR_GAIN      = 2'd1,
      CSR_TABLE_LEN = 2'd2
   } csr_reg_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_TICK  = 1'b1
   } req_kind_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic req_ready;
      logic ram_we;
      logic read_next;
      logic cap_s0;
      logic mul_diff;
      logic mul_gain;
      logic load_out;
      logic take_sum;
      logic take_sum_wrap;
      logic mod_from_phase;
      logic mod_from_sum;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_is_tick;
      logic phase_stale;
      logic sum_in_range;
      logic sum_one_wrap;
      logic mod_busy;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/wtosc_ifs.sv =====
// Handshake channel interfaces: request, response and register write.
interface wtosc_req_if;
   import wtosc_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [ADDR_W-1:0]   table_addr;
   sample_type          table_value;

   modport source (output valid, output req_type, output table_addr, output table_value,
                   input ready);
   modport sink   (input valid, input req_type, input table_addr, input table_value,
                   output ready);
endinterface

interface wtosc_rsp_if;
   import wtosc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wtosc_csr_if;
   import wtosc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== src/wavetable_oscillator_linear_interp_core.sv =====
// Top level of the wavetable oscillator with linear interpolation.
//
//   channel   dir   handshake            word
//   req_port  in    valid/ready          req_type, table_addr, table_value
//   rsp_port  out   valid/ready          sample (one per tick item)
//   csr_port  in    valid/ready (ready=1) addr, wdata
//
// A tick makes two reads from the single-port table, a multiply for the interpolation
// and one for the gain, then the phase update. When the step carries the phase past the
// table end by a full length or more, the bit-serial remainder unit reduces it; a phase
// left out of range by a shorter table is first reduced in the remainder unit, and then
// the first read is repeated. Reset is synchronous; it clears the phase and increment and
// sets gain and length to their reset values; the table is not cleared. A stalled output
// word holds the tick in its last step, and no new request is taken until that word
// is loaded.
module wavetable_oscillator_linear_interp_core #(
   parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   wtosc_req_if.sink   req_port,
   wtosc_rsp_if.source rsp_port,
   wtosc_csr_if.sink   csr_port
);
   import wtosc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   wtosc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   wtosc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .csr_port (csr_port),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// ===== src/wtosc_ram.sv =====
// Generic single-port RAM with registered read data.
module wtosc_ram #(
   parameter int WIDTH = wtosc_pkg::SAMPLE_W,
   parameter int DEPTH = wtosc_pkg::TABLE_DEPTH_DEF + 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/wtosc_ctrl.sv =====
// Sequencer for table writes and the read, interpolate, scale and phase-wrap steps of a tick.
module wtosc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  wtosc_pkg::dp_status_type status,
   output wtosc_pkg::dp_cmd_type    cmd
);
   import wtosc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ0,
      ST_READ1,
      ST_MUL0,
      ST_MUL1,
      ST_DONE,
      ST_REDUCE,
      ST_WRAP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               state_in = status.req_is_tick ? ST_READ0 : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.ram_we = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_READ0: begin
            // a shortened table leaves the phase out of range: reduce it first
            if (status.phase_stale) begin
               cmd.mod_from_phase = 1'b1;
               state_in           = ST_REDUCE;
            end else begin
               state_in = ST_READ1;
            end
         end
         ST_READ1: begin
            cmd.read_next = 1'b1;
            cmd.cap_s0    = 1'b1;
            state_in      = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul_diff = 1'b1;
            state_in     = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_gain = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output word has somewhere to go
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.sum_in_range) begin
                  cmd.take_sum = 1'b1;
                  state_in     = ST_IDLE;
               end else if (status.sum_one_wrap) begin
                  cmd.take_sum_wrap = 1'b1;
                  state_in          = ST_IDLE;
               end else begin
                  cmd.mod_from_sum = 1'b1;
                  state_in         = ST_WRAP;
               end
            end
         end
         ST_REDUCE: begin
            if (!status.mod_busy) begin
               state_in = ST_READ0;
            end
         end
         ST_WRAP: begin
            if (!status.mod_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/wtosc_datapath.sv =====
// Registers, sample table, interpolation arithmetic, remainder unit and output stage.
module wtosc_datapath #(
   parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   wtosc_req_if.sink                req_port,
   wtosc_rsp_if.source              rsp_port,
   wtosc_csr_if.sink                csr_port,
   input  wtosc_pkg::dp_cmd_type    cmd,
   output wtosc_pkg::dp_status_type status
);
   import wtosc_pkg::*;

   localparam int RAM_DEPTH = TABLE_DEPTH + 1;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int CNT_W     = $clog2(NUM_W + 1);
   localparam int PSH_W     = MUL_W - FRAC_W;
   localparam int SSH_W     = GMUL_W - GAIN_FRAC;
   localparam int TOP_W     = SSH_W - SAMPLE_W + 1;

   // configuration
   logic [INC_W-1:0]  inc_ff, inc_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  len_eff;
   logic [NUM_W-1:0]  len_x;

   // phase and remainder unit control
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic              mod_busy_ff, mod_busy_in;
   logic [CNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic              out_valid_ff, out_valid_in;

   // payload
   logic [ADDR_W-1:0]   addr_ff;
   logic [SAMPLE_W-1:0] value_ff;
   logic [SAMPLE_W-1:0] s0_ff, s0_in;
   logic [MUL_W-1:0]    prod_ff, prod_in;
   logic [GMUL_W-1:0]   scaled_ff, scaled_in;
   logic [PH_W:0]       sum_ff, sum_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   sample_type          out_sample_ff, out_sample_in;

   logic                req_take;
   logic [LEN_W-1:0]    phase_int;
   logic [FRAC_W-1:0]   phase_frac;
   logic [NUM_W-1:0]    rd_idx;
   logic [RAM_AW-1:0]   ram_addr;
   logic                ram_we;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                addr_ok;
   logic [SAMPLE_W:0]   diff;
   logic [PSH_W-1:0]    interp_wide;
   logic [SAMPLE_W:0]   interp;
   logic [SSH_W-1:0]    scaled_sh;
   logic [TOP_W-1:0]    scaled_top;
   logic [SAMPLE_W-1:0] sat;
   logic [NUM_W-1:0]    sum_int;
   logic [NUM_W-1:0]    sum_sub;
   logic [NUM_W-1:0]    shifted;
   logic [LEN_W-1:0]    rem_step;

   assign req_take      = req_port.valid & req_port.ready;
   assign req_port.ready = cmd.req_ready;
   assign csr_port.ready = 1'b1;

   always_comb begin
      inc_in  = inc_ff;
      gain_in = gain_ff;
      len_in  = len_ff;
      if (csr_port.valid) begin
         unique case (csr_port.addr)
            CSR_PHASE_INC: inc_in  = csr_port.wdata[INC_W-1:0];
            CSR_GAIN:      gain_in = csr_port.wdata[GAIN_W-1:0];
            CSR_TABLE_LEN: len_in  = csr_port.wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the programmed length to between MIN_LEN and what the table holds
   always_comb begin
      if (len_ff < LEN_W'(MIN_LEN)) begin
         len_eff = LEN_W'(MIN_LEN);
      end else if (32'(len_ff) > 32'(TABLE_DEPTH)) begin
         len_eff = LEN_W'(TABLE_DEPTH);
      end else begin
         len_eff = len_ff;
      end
   end
   assign len_x = {1'b0, len_eff};

   assign phase_int  = phase_ff[PH_W-1:FRAC_W];
   assign phase_frac = phase_ff[FRAC_W-1:0];

   // sample table
   assign addr_ok  = 32'(addr_ff) <= 32'(TABLE_DEPTH);
   assign ram_we   = cmd.ram_we & addr_ok;
   assign rd_idx   = cmd.read_next ? ({1'b0, phase_int} + NUM_W'(1)) : {1'b0, phase_int};
   assign ram_addr = cmd.ram_we ? RAM_AW'(addr_ff) : RAM_AW'(rd_idx);

   wtosc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (value_ff),
      .rdata (ram_rdata)
   );

   // interpolation: s0 + floor((s1 - s0) * frac / 2^FRAC_W)
   assign diff    = {ram_rdata[SAMPLE_W-1], ram_rdata} - {s0_ff[SAMPLE_W-1], s0_ff};
   assign prod_in = {{(MUL_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff} * MUL_W'(phase_frac);
   assign s0_in   = cmd.cap_s0 ? ram_rdata : s0_ff;
   assign sum_in  = {1'b0, phase_ff} + (PH_W+1)'(inc_ff);

   assign interp_wide = {{(PSH_W-SAMPLE_W){s0_ff[SAMPLE_W-1]}}, s0_ff}
                      + prod_ff[MUL_W-1:FRAC_W];
   assign interp      = interp_wide[SAMPLE_W:0];
   assign scaled_in   = {{(GMUL_W-SAMPLE_W-1){interp[SAMPLE_W]}}, interp}
                      * GMUL_W'(gain_ff);

   // saturate floor(scaled / 2^15) to the sample range
   assign scaled_sh  = scaled_ff[GMUL_W-1:GAIN_FRAC];
   assign scaled_top = scaled_sh[SSH_W-1:SAMPLE_W-1];
   always_comb begin
      if (scaled_sh[SSH_W-1] && !(&scaled_top)) begin
         sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else if (!scaled_sh[SSH_W-1] && (|scaled_top)) begin
         sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         sat = scaled_sh[SAMPLE_W-1:0];
      end
   end

   // phase advance and wrap
   assign sum_int = sum_ff[PH_W:FRAC_W];
   assign sum_sub = sum_int - len_x;

   // remainder unit: one numerator bit per cycle
   assign shifted  = {rem_ff, num_ff[NUM_W-1]};
   assign rem_step = (shifted >= len_x) ? LEN_W'(shifted - len_x) : shifted[LEN_W-1:0];

   always_comb begin
      phase_in    = phase_ff;
      mod_busy_in = mod_busy_ff;
      mod_cnt_in  = mod_cnt_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      frac_in     = frac_ff;
      if (cmd.mod_from_phase || cmd.mod_from_sum) begin
         num_in      = cmd.mod_from_phase ? {1'b0, phase_int} : sum_int;
         frac_in     = cmd.mod_from_phase ? phase_frac : sum_ff[FRAC_W-1:0];
         rem_in      = '0;
         mod_busy_in = 1'b1;
         mod_cnt_in  = CNT_W'(NUM_W);
      end else if (mod_busy_ff) begin
         num_in     = num_ff << 1;
         rem_in     = rem_step;
         mod_cnt_in = mod_cnt_ff - CNT_W'(1);
         if (mod_cnt_ff == CNT_W'(1)) begin
            mod_busy_in = 1'b0;
            phase_in    = {rem_step, frac_ff};
         end
      end else if (cmd.take_sum) begin
         phase_in = sum_ff[PH_W-1:0];
      end else if (cmd.take_sum_wrap) begin
         phase_in = {sum_sub[LEN_W-1:0], sum_ff[FRAC_W-1:0]};
      end
   end

   // output word register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      if (cmd.load_out) begin
         out_valid_in  = 1'b1;
         out_sample_in = sample_type'(sat);
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_port.valid  = out_valid_ff;
   assign rsp_port.sample = out_sample_ff;

   assign status.req_valid    = req_port.valid;
   assign status.req_is_tick  = req_port.req_type == REQ_TICK;
   assign status.phase_stale  = phase_int >= len_eff;
   assign status.sum_in_range = sum_int < len_x;
   assign status.sum_one_wrap = sum_sub < len_x;
   assign status.mod_busy     = mod_busy_ff;
   assign status.out_free     = !out_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff       <= '0;
         gain_ff      <= GAIN_W'(RESET_GAIN);
         len_ff       <= LEN_W'(RESET_LEN);
         phase_ff     <= '0;
         mod_busy_ff  <= 1'b0;
         mod_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         inc_ff       <= inc_in;
         gain_ff      <= gain_in;
         len_ff       <= len_in;
         phase_ff     <= phase_in;
         mod_busy_ff  <= mod_busy_in;
         mod_cnt_ff   <= mod_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff  <= req_port.table_addr;
         value_ff <= req_port.table_value;
      end
      s0_ff         <= s0_in;
      if (cmd.mul_diff) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
      if (cmd.mul_gain) begin
         scaled_ff <= scaled_in;
      end
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      frac_ff       <= frac_in;
      out_sample_ff <= out_sample_in;
   end

endmodule

// ===== dv/wtosc_checker.sv =====
// Scoreboard for the wavetable oscillator: tracks registers and table, predicts and checks samples.
module wtosc_checker (
   input  logic        clock,
   input  logic        reset,
   wtosc_req_if        req,
   wtosc_rsp_if        rsp,
   wtosc_csr_if        csr,
   output int unsigned fail_count,
   output int unsigned outstanding
);
   import wtosc_pkg::*;

   localparam int     MAX_REPORTS = 10;
   localparam longint SAMPLE_HI   = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO   = -SAMPLE_HI - 1;

   logic [INC_W-1:0]  phase_step;
   logic [GAIN_W-1:0] level;
   logic [LEN_W-1:0]  cycle_len;
   longint            phase;
   sample_type        wave[0:TABLE_DEPTH_DEF];
   sample_type        expected_samples[$];
   int unsigned       errors = 0;

   // Interpolate between two neighbouring entries, apply gain, saturate, advance the phase.
   function automatic sample_type synth_sample();
      longint eff, span, idx, frac, s0, s1, g, step, interp, scaled;
      eff = cycle_len;
      if (eff < MIN_LEN)
         eff = MIN_LEN;
      if (eff > TABLE_DEPTH_DEF)
         eff = TABLE_DEPTH_DEF;
      span = eff << FRAC_W;
      // length was shortened under a running phase
      if (phase >= span)
         phase = phase % span;
      idx    = phase >> FRAC_W;
      frac   = phase & ((longint'(1) << FRAC_W) - 1);
      s0     = wave[idx];
      s1     = wave[idx + 1];
      g      = level;
      step   = phase_step;
      interp = s0 + (((s1 - s0) * frac) >>> FRAC_W);
      scaled = (interp * g) >>> GAIN_FRAC;
      if (scaled > SAMPLE_HI)
         scaled = SAMPLE_HI;
      if (scaled < SAMPLE_LO)
         scaled = SAMPLE_LO;
      phase = (phase + step) % span;
      return scaled[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         phase_step = '0;
         level      = GAIN_W'(RESET_GAIN);
         cycle_len  = LEN_W'(RESET_LEN);
         phase      = 0;
         expected_samples.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.addr)
               CSR_PHASE_INC: phase_step = csr.wdata[INC_W-1:0];
               CSR_GAIN:      level      = csr.wdata[GAIN_W-1:0];
               CSR_TABLE_LEN: cycle_len  = csr.wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (req.req_type == REQ_TICK)
               expected_samples.push_back(synth_sample());
            else if (req.table_addr <= TABLE_DEPTH_DEF)
               wave[req.table_addr] = req.table_value;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_samples.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("unexpected sample word %0d, none pending", rsp.sample);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp.sample !== want) begin
                  if (errors < MAX_REPORTS)
                     $display("sample mismatch: expected %0d, got %0d", want, rsp.sample);
                  errors++;
               end
            end
         end
      end
      outstanding = expected_samples.size();
      fail_count  = errors;
   end

endmodule

// ===== dv/tb_wavetable_oscillator_linear_interp_core.sv =====
// Testbench top for the wavetable oscillator: clock, reset, stimulus, idling and verdict.
module tb_wavetable_oscillator_linear_interp_core;
   import wtosc_pkg::*;

   localparam int                    HALF_PERIOD    = 6;
   localparam int                    IDLE_PCT       = 9;
   localparam int                    SETTLE_CYCLES  = 40;
   localparam int                    WATCHDOG_LIMIT = 3000;
   localparam int                    RANDOM_ITEMS   = 400;
   localparam int                    MAX_INC        = (1 << INC_W) - 1;
   localparam int                    UNIT_PHASE     = 1 << FRAC_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE      = 2'd3;
   localparam sample_type            PEAK           = 16'h7FFF;
   localparam sample_type            TROUGH         = 16'h8000;

   logic        clock;
   logic        reset;
   logic        calm;
   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned quiet_cycles = 0;

   wtosc_req_if req_ch();
   wtosc_rsp_if rsp_ch();
   wtosc_csr_if csr_ch();

   wavetable_oscillator_linear_interp_core dut (
      .clock,
      .reset,
      .req_port(req_ch),
      .rsp_port(rsp_ch),
      .csr_port(csr_ch)
   );

   wtosc_checker u_scoreboard (
      .clock,
      .reset,
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch),
      .fail_count,
      .outstanding
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Give up when nothing has moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input req_kind_type kind, input logic [ADDR_W-1:0] addr,
                            input sample_type value);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.req_type    = kind;
      req_ch.table_addr  = addr;
      req_ch.table_value = value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_tick();
      send_word(REQ_TICK, ADDR_W'($urandom), sample_type'($urandom));
   endtask

   // Hold off until every sample has come back and the block has settled.
   task automatic drain_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.addr  = idx;
      csr_ch.wdata = data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] inc, input logic [CSR_DATA_W-1:0] gain,
                            input logic [CSR_DATA_W-1:0] len);
      drain_idle();
      write_reg(CSR_PHASE_INC, inc);
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_TABLE_LEN, len);
   endtask

   initial begin
      int                    random_done;
      int                    burst;
      logic [CSR_DATA_W-1:0] inc;
      logic [CSR_DATA_W-1:0] gain;
      logic [CSR_DATA_W-1:0] len;
      logic [ADDR_W-1:0]     addr;

      reset              = 1'b1;
      calm               = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_WRITE;
      req_ch.table_addr  = '0;
      req_ch.table_value = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.addr        = CSR_PHASE_INC;
      csr_ch.wdata       = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Fill every entry, guard included, so no tick reads an unwritten word.
      for (int a = 0; a <= TABLE_DEPTH_DEF; a++)
         send_word(REQ_WRITE, ADDR_W'(a), sample_type'($urandom));

      // Full-scale steps at the start of the table.
      send_word(REQ_WRITE, ADDR_W'(0), PEAK);
      send_word(REQ_WRITE, ADDR_W'(1), TROUGH);
      send_word(REQ_WRITE, ADDR_W'(2), TROUGH);
      send_word(REQ_WRITE, ADDR_W'(3), PEAK);
      // Out-of-table writes must leave the table alone.
      send_word(REQ_WRITE, ADDR_W'(TABLE_DEPTH_DEF + 1), TROUGH);
      send_word(REQ_WRITE, '1, PEAK);
      send_tick();

      configure(CSR_DATA_W'(UNIT_PHASE / 2), CSR_DATA_W'(RESET_GAIN), CSR_DATA_W'(RESET_LEN));
      repeat (4) send_tick();
      // Gain above unity saturates.
      configure(CSR_DATA_W'(UNIT_PHASE / 4), CSR_DATA_W'(16'hFFFF), CSR_DATA_W'(RESET_LEN));
      repeat (2) send_tick();
      // Zero gain, length clamped up to the minimum, increment at full width.
      configure(CSR_DATA_W'(MAX_INC), '0, '0);
      repeat (3) send_tick();
      // Length clamped down to the table depth.
      configure(CSR_DATA_W'(MAX_INC), CSR_DATA_W'(RESET_GAIN), '1);
      repeat (2) send_tick();
      // Run the phase far out, then shorten the table under it.
      configure(CSR_DATA_W'(1000 * UNIT_PHASE + 16'h1234), CSR_DATA_W'(RESET_GAIN),
                CSR_DATA_W'(RESET_LEN));
      repeat (2) send_tick();
      configure(CSR_DATA_W'(UNIT_PHASE + 1), CSR_DATA_W'(RESET_GAIN), CSR_DATA_W'(3));
      repeat (2) send_tick();
      // Unused register index has no effect.
      drain_idle();
      write_reg(CSR_SPARE, '1);
      send_tick();

      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         case ($urandom_range(3))
            0:       inc = '0;
            1:       inc = CSR_DATA_W'(MAX_INC);
            2:       inc = CSR_DATA_W'($urandom_range(0, 16 * UNIT_PHASE));
            default: inc = CSR_DATA_W'($urandom & MAX_INC);
         endcase
         case ($urandom_range(4))
            0:       gain = '0;
            1:       gain = CSR_DATA_W'(RESET_GAIN);
            2:       gain = CSR_DATA_W'(16'hFFFF);
            3:       gain = CSR_DATA_W'($urandom & MAX_INC);
            default: gain = CSR_DATA_W'($urandom_range(0, RESET_GAIN));
         endcase
         case ($urandom_range(6))
            0:       len = CSR_DATA_W'($urandom_range(0, 1));
            1:       len = CSR_DATA_W'(MIN_LEN);
            2:       len = CSR_DATA_W'(RESET_LEN);
            3:       len = CSR_DATA_W'($urandom_range(1025, 2047));
            4:       len = CSR_DATA_W'($urandom & MAX_INC);
            default: len = CSR_DATA_W'($urandom_range(MIN_LEN, 64));
         endcase
         configure(inc, gain, len);
         burst = $urandom_range(20, 90);
         for (int k = 0; k < burst; k++) begin
            calm = (random_done >= 100) && (random_done < 200);
            if ($urandom_range(99) < 80) begin
               send_tick();
            end else begin
               if ($urandom_range(9) == 0)
                  addr = ADDR_W'($urandom_range(TABLE_DEPTH_DEF + 1, (1 << ADDR_W) - 1));
               else
                  addr = ADDR_W'($urandom_range(0, TABLE_DEPTH_DEF));
               send_word(REQ_WRITE, addr, sample_type'($urandom));
            end
            random_done++;
         end
      end
      calm = 1'b0;

      drain_idle();
      if (fail_count == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/wtosc_pkg.sv
src/wtosc_ifs.sv
src/wtosc_ram.sv
src/wtosc_ctrl.sv
src/wtosc_datapath.sv
src/wavetable_oscillator_linear_interp_core.sv
dv/wtosc_checker.sv
dv/tb_wavetable_oscillator_linear_interp_core.sv
